// ===== hw/rtl/crr_pkg.sv =====
package crr_pkg;

  localparam int COORD_BITS  = 16;
  localparam int CENTER_BITS = 16;
  localparam int RADIUS_BITS = 15;

  localparam int MAX_BITS = (COORD_BITS > CENTER_BITS) ? COORD_BITS : CENTER_BITS;
  localparam int EXT_W    = MAX_BITS + 3;
  localparam int R2_W     = RADIUS_BITS + 1;
  localparam int RSQ_W    = 2 * RADIUS_BITS;
  localparam int RSUM_W   = RSQ_W + 1;
  localparam int ESQ_W    = 2 * R2_W;
  localparam int ESUM_W   = ESQ_W + 1;

  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 4;
  localparam int REG_IDX_W  = CFG_ADDR_W - 2;

  localparam logic [REG_IDX_W-1:0] REG_CENTER_X = REG_IDX_W'(0);
  localparam logic [REG_IDX_W-1:0] REG_CENTER_Y = REG_IDX_W'(1);
  localparam logic [REG_IDX_W-1:0] REG_RADIUS   = REG_IDX_W'(2);

  typedef logic signed [COORD_BITS-1:0]  coord_t;
  typedef logic signed [CENTER_BITS-1:0] center_t;
  typedef logic [RADIUS_BITS-1:0]        radius_t;
  typedef logic signed [EXT_W-1:0]       ext_t;

  typedef enum logic [1:0] {
    REL_CIRCLE_HOLDS_RECT,
    REL_RECT_HOLDS_CIRCLE,
    REL_OVERLAP,
    REL_DISJOINT
  } rel_t;

  typedef struct packed {
    center_t center_x;
    center_t center_y;
    radius_t radius;
  } cfg_t;

  function automatic ext_t ext_coord(coord_t v);
    return ext_t'(v);
  endfunction

  function automatic ext_t ext_center(center_t v);
    return ext_t'(v);
  endfunction

  function automatic ext_t ext_radius(radius_t v);
    return ext_t'({1'b0, v});
  endfunction

  function automatic ext_t abs_ext(ext_t v);
    return v[EXT_W-1] ? -v : v;
  endfunction

endpackage

// ===== hw/rtl/crr_rect_if.sv =====
interface crr_rect_if;
  logic            valid;
  logic            ready;
  crr_pkg::coord_t rect_left;
  crr_pkg::coord_t rect_right;
  crr_pkg::coord_t rect_bottom;
  crr_pkg::coord_t rect_top;

  modport source (
    output valid, rect_left, rect_right, rect_bottom, rect_top,
    input  ready
  );

  modport sink (
    input  valid, rect_left, rect_right, rect_bottom, rect_top,
    output ready
  );
endinterface

// ===== hw/rtl/crr_rel_if.sv =====
interface crr_rel_if;
  logic          valid;
  logic          ready;
  crr_pkg::rel_t relation;

  modport source (
    output valid, relation,
    input  ready
  );

  modport sink (
    input  valid, relation,
    output ready
  );
endinterface

// ===== hw/rtl/crr_cfg_regs.sv =====
module crr_cfg_regs (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [crr_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [crr_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [crr_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                             pready,
  output crr_pkg::cfg_t                    cfg
);

  crr_pkg::cfg_t                    cfg_r;
  logic [crr_pkg::REG_IDX_W-1:0]    idx;
  logic                             wr_en;

  assign idx    = paddr[crr_pkg::CFG_ADDR_W-1:2];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (wr_en) begin
      case (idx)
        crr_pkg::REG_CENTER_X: begin
          cfg_r.center_x <= pwdata[crr_pkg::CENTER_BITS-1:0];
        end
        crr_pkg::REG_CENTER_Y: begin
          cfg_r.center_y <= pwdata[crr_pkg::CENTER_BITS-1:0];
        end
        crr_pkg::REG_RADIUS: begin
          cfg_r.radius <= pwdata[crr_pkg::RADIUS_BITS-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (idx)
      crr_pkg::REG_CENTER_X: prdata = crr_pkg::CFG_DATA_W'(cfg_r.center_x);
      crr_pkg::REG_CENTER_Y: prdata = crr_pkg::CFG_DATA_W'(cfg_r.center_y);
      crr_pkg::REG_RADIUS:   prdata = crr_pkg::CFG_DATA_W'(cfg_r.radius);
      default:               prdata = '0;
    endcase
  end

endmodule

// ===== hw/rtl/crr_pipe.sv =====
module crr_pipe (
  input  logic             clk,
  input  logic             rst_n,
  input  crr_pkg::cfg_t    cfg,
  crr_rect_if.sink         in_ch,
  crr_rel_if.source        out_ch
);

  logic en;
  logic v0_r, v1_r, v2_r, v3_r, v4_r, out_valid_r;

  crr_pkg::ext_t cx_e, cy_e, r_e, r2_e;

  // Stage 0: input register.
  crr_pkg::coord_t l0_r, rt0_r, b0_r, t0_r;

  // Stage 1: edge differences and sums.
  crr_pkg::ext_t xd1_nxt [2];
  crr_pkg::ext_t yd1_nxt [2];
  crr_pkg::ext_t xd1_r   [2];
  crr_pkg::ext_t yd1_r   [2];
  crr_pkg::ext_t sumx1_nxt, sumy1_nxt, hw1_nxt, hh1_nxt;
  crr_pkg::ext_t sumx1_r, sumy1_r, hw1_r, hh1_r;
  logic          hold1_nxt, hold1_r;
  crr_pkg::ext_t l_e, rt_e, b_e, t_e;

  // Stage 2: magnitudes and bounds.
  crr_pkg::ext_t           ax2 [2];
  crr_pkg::ext_t           ay2 [2];
  logic [1:0]              nearx2_nxt, neary2_nxt, nearx2_r, neary2_r;
  crr_pkg::radius_t        xa2_nxt [2];
  crr_pkg::radius_t        ya2_nxt [2];
  crr_pkg::radius_t        xa2_r   [2];
  crr_pkg::radius_t        ya2_r   [2];
  crr_pkg::ext_t           dx2raw_nxt, dy2raw_nxt, hwr2_nxt, hhr2_nxt;
  crr_pkg::ext_t           dx2raw_r, dy2raw_r, hwr2_r, hhr2_r, hw2_r, hh2_r;
  logic                    hold2_r;

  // Stage 3: corner squares and overlap classification.
  crr_pkg::ext_t           dx3, dy3, ex3_full, ey3_full;
  logic [crr_pkg::RSQ_W-1:0] xsq3_nxt [2];
  logic [crr_pkg::RSQ_W-1:0] ysq3_nxt [2];
  logic [crr_pkg::RSQ_W-1:0] xsq3_r   [2];
  logic [crr_pkg::RSQ_W-1:0] ysq3_r   [2];
  logic [crr_pkg::RSQ_W-1:0] rr3_nxt, rr3_r;
  logic [crr_pkg::R2_W-1:0]  ex3_r, ey3_r;
  logic                      far3_nxt, inside3_nxt, far3_r, inside3_r;
  logic [1:0]                nearx3_r, neary3_r;
  logic                      hold3_r;

  // Stage 4: corner containment and edge-distance squares.
  logic                      contain4_nxt, contain4_r;
  logic [crr_pkg::ESQ_W-1:0] exsq4_nxt, eysq4_nxt, exsq4_r, eysq4_r, r2sq4_r;
  logic                      far4_r, inside4_r, hold4_r;

  // Output stage.
  logic                      hit;
  logic [crr_pkg::ESUM_W-1:0] esum;
  crr_pkg::rel_t             rel_nxt, rel_r;

  assign en           = !out_valid_r || out_ch.ready;
  assign in_ch.ready  = en;
  assign out_ch.valid = out_valid_r;
  assign out_ch.relation = rel_r;

  assign cx_e = crr_pkg::ext_center(cfg.center_x);
  assign cy_e = crr_pkg::ext_center(cfg.center_y);
  assign r_e  = crr_pkg::ext_radius(cfg.radius);
  assign r2_e = r_e + r_e;

  always_comb begin
    l_e  = crr_pkg::ext_coord(l0_r);
    rt_e = crr_pkg::ext_coord(rt0_r);
    b_e  = crr_pkg::ext_coord(b0_r);
    t_e  = crr_pkg::ext_coord(t0_r);
    xd1_nxt[0] = cx_e - l_e;
    xd1_nxt[1] = cx_e - rt_e;
    yd1_nxt[0] = cy_e - b_e;
    yd1_nxt[1] = cy_e - t_e;
    sumx1_nxt  = l_e + rt_e;
    sumy1_nxt  = b_e + t_e;
    hw1_nxt    = rt_e - l_e;
    hh1_nxt    = t_e - b_e;
    hold1_nxt  = (l_e < cx_e - r_e) && (rt_e > cx_e + r_e) &&
                 (b_e < cy_e - r_e) && (t_e > cy_e + r_e);
  end

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      ax2[i]        = crr_pkg::abs_ext(xd1_r[i]);
      ay2[i]        = crr_pkg::abs_ext(yd1_r[i]);
      nearx2_nxt[i] = ax2[i] <= r_e;
      neary2_nxt[i] = ay2[i] <= r_e;
      xa2_nxt[i]    = ax2[i][crr_pkg::RADIUS_BITS-1:0];
      ya2_nxt[i]    = ay2[i][crr_pkg::RADIUS_BITS-1:0];
    end
    dx2raw_nxt = cx_e + cx_e - sumx1_r;
    dy2raw_nxt = cy_e + cy_e - sumy1_r;
    hwr2_nxt   = hw1_r + r2_e;
    hhr2_nxt   = hh1_r + r2_e;
  end

  always_comb begin
    dx3         = crr_pkg::abs_ext(dx2raw_r);
    dy3         = crr_pkg::abs_ext(dy2raw_r);
    far3_nxt    = (dx3 > hwr2_r) || (dy3 > hhr2_r);
    inside3_nxt = (dx3 <= hw2_r) || (dy3 <= hh2_r);
    ex3_full    = dx3 - hw2_r;
    ey3_full    = dy3 - hh2_r;
    for (int i = 0; i < 2; i++) begin
      xsq3_nxt[i] = crr_pkg::RSQ_W'(xa2_r[i]) * crr_pkg::RSQ_W'(xa2_r[i]);
      ysq3_nxt[i] = crr_pkg::RSQ_W'(ya2_r[i]) * crr_pkg::RSQ_W'(ya2_r[i]);
    end
    rr3_nxt = crr_pkg::RSQ_W'(cfg.radius) * crr_pkg::RSQ_W'(cfg.radius);
  end

  always_comb begin
    contain4_nxt = 1'b1;
    for (int i = 0; i < 2; i++) begin
      for (int j = 0; j < 2; j++) begin
        if (!(nearx3_r[i] && neary3_r[j] &&
              (crr_pkg::RSUM_W'(xsq3_r[i]) + crr_pkg::RSUM_W'(ysq3_r[j]) <=
               crr_pkg::RSUM_W'(rr3_r)))) begin
          contain4_nxt = 1'b0;
        end
      end
    end
    exsq4_nxt = crr_pkg::ESQ_W'(ex3_r) * crr_pkg::ESQ_W'(ex3_r);
    eysq4_nxt = crr_pkg::ESQ_W'(ey3_r) * crr_pkg::ESQ_W'(ey3_r);
  end

  always_comb begin
    esum = crr_pkg::ESUM_W'(exsq4_r) + crr_pkg::ESUM_W'(eysq4_r);
    hit  = !far4_r && (inside4_r || (esum <= crr_pkg::ESUM_W'(r2sq4_r)));
    if (contain4_r) begin
      rel_nxt = crr_pkg::REL_CIRCLE_HOLDS_RECT;
    end else if (hold4_r) begin
      rel_nxt = crr_pkg::REL_RECT_HOLDS_CIRCLE;
    end else if (hit) begin
      rel_nxt = crr_pkg::REL_OVERLAP;
    end else begin
      rel_nxt = crr_pkg::REL_DISJOINT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r        <= 1'b0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      v0_r        <= in_ch.valid;
      v1_r        <= v0_r;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      v4_r        <= v3_r;
      out_valid_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      l0_r  <= in_ch.rect_left;
      rt0_r <= in_ch.rect_right;
      b0_r  <= in_ch.rect_bottom;
      t0_r  <= in_ch.rect_top;

      xd1_r   <= xd1_nxt;
      yd1_r   <= yd1_nxt;
      sumx1_r <= sumx1_nxt;
      sumy1_r <= sumy1_nxt;
      hw1_r   <= hw1_nxt;
      hh1_r   <= hh1_nxt;
      hold1_r <= hold1_nxt;

      nearx2_r <= nearx2_nxt;
      neary2_r <= neary2_nxt;
      xa2_r    <= xa2_nxt;
      ya2_r    <= ya2_nxt;
      dx2raw_r <= dx2raw_nxt;
      dy2raw_r <= dy2raw_nxt;
      hwr2_r   <= hwr2_nxt;
      hhr2_r   <= hhr2_nxt;
      hw2_r    <= hw1_r;
      hh2_r    <= hh1_r;
      hold2_r  <= hold1_r;

      xsq3_r    <= xsq3_nxt;
      ysq3_r    <= ysq3_nxt;
      rr3_r     <= rr3_nxt;
      ex3_r     <= ex3_full[crr_pkg::R2_W-1:0];
      ey3_r     <= ey3_full[crr_pkg::R2_W-1:0];
      far3_r    <= far3_nxt;
      inside3_r <= inside3_nxt;
      nearx3_r  <= nearx2_r;
      neary3_r  <= neary2_r;
      hold3_r   <= hold2_r;

      contain4_r <= contain4_nxt;
      exsq4_r    <= exsq4_nxt;
      eysq4_r    <= eysq4_nxt;
      r2sq4_r    <= {rr3_r, 2'b00};
      far4_r     <= far3_r;
      inside4_r  <= inside3_r;
      hold4_r    <= hold3_r;

      rel_r <= rel_nxt;
    end
  end

endmodule

// ===== hw/rtl/circle_rect_relation.sv =====
// Throughput: one rectangle per cycle through a six-register pipeline, unless the output stalls.
// The whole pipeline holds while a result beat waits on the output, so input
// ready follows output ready combinationally.
// Synchronous active-low reset clears all pipeline valid flags and sets the
// circle center and radius registers to zero.
module circle_rect_relation (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [crr_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [crr_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [crr_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                             pready,
  crr_rect_if.sink                         in_ch,
  crr_rel_if.source                        out_ch
);

  crr_pkg::cfg_t cfg;

  crr_cfg_regs u_cfg_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  crr_pipe u_pipe (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

endmodule

// ===== hw/rtl/crr_checker.sv =====
module crr_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] out_relation
);

  a_out_valid_holds: assert property (
    @(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid
  ) else $error("result beat dropped while stalled");

  a_out_payload_holds: assert property (
    @(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_relation)
  ) else $error("result beat changed while stalled");

  a_in_ready_when_free: assert property (
    @(posedge clk) disable iff (!rst_n)
    !(out_valid && !out_ready) |-> in_ready
  ) else $error("input stalled although output is free");

  a_in_stall_with_out: assert property (
    @(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready
  ) else $error("input accepted while pipeline is held");

  a_reset_clears_out: assert property (
    @(posedge clk)
    !rst_n |=> !out_valid
  ) else $error("result valid after reset");

endmodule

bind circle_rect_relation crr_checker u_crr_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .out_relation (out_ch.relation)
);
